>>> rtl/core/rlq_pkg.sv
package rlq_pkg;

  // Table size and derived index width
  localparam int NUM_TASKS = 64;
  localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  // Fixed field widths of the request and result transactions
  localparam int TASK_W = 6;
  localparam int ERR_W  = 2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [TASK_W-1:0] task_t;

  // Requested operation
  typedef enum logic [0:0] {
    FUNC_ADD    = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  // Result status
  typedef enum logic [ERR_W-1:0] {
    ERR_OK              = 2'd0,
    ERR_ADD_LISTED      = 2'd1,
    ERR_REMOVE_UNLISTED = 2'd2
  } err_t;

  // Request held in the working stage
  typedef struct packed {
    func_t func;
    idx_t  idx;
    logic  in_range;
  } req_t;

  // Map a task number onto a table index
  function automatic idx_t to_idx(input task_t t);
    return IDX_W'(t);
  endfunction

  // True when a task number has a table entry
  function automatic logic task_in_range(input task_t t);
    return (32'(t) < NUM_TASKS);
  endfunction

endpackage

>>> rtl/core/ready_list_linked_queue_top.sv
// Ready list of task numbers kept as a circular doubly linked list.
//
// Request channel (in_valid/in_ready): func selects add at tail or remove,
// task_req names the task. Result channel (out_valid/out_ready): every
// request returns one transaction with list_empty, first_task (head after
// the step, 0 when empty) and error (add of a listed task, remove of an
// unlisted task; a refused request leaves the list unchanged).
//
// The request and the link words read for it are registered in the working
// stage, then one pass of logic updates the list and loads the result
// register. One request is taken per cycle while out_ready holds.
// The next and previous link tables are single-port-write RAMs; the tail's
// next link and the head's previous link are implied by the head and tail
// registers, so each request writes each table at most once.
//
// Reset empties the list at once (membership bits clear together); no
// sweep of the link tables is needed. When out_ready is low the result
// holds, one more request waits in the working stage, and in_ready drops.
module ready_list_linked_queue_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  logic [5:0]            task_req,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  list_empty,
  output logic [5:0]            first_task,
  output logic [1:0]            error
);

  import rlq_pkg::*;

  // List state
  logic [NUM_TASKS-1:0] listed, listed_next;
  idx_t                 head, head_next;
  idx_t                 tail, tail_next;
  logic                 empty_flag, empty_next;

  // Working stage
  logic a_valid;
  req_t a_req;
  logic next_byp, prev_byp;
  idx_t next_byp_data, prev_byp_data;

  // Link table ports
  logic next_we, prev_we;
  idx_t next_waddr, prev_waddr, next_wdata, prev_wdata;
  idx_t next_rdata, prev_rdata;
  idx_t in_idx;

  logic advance, accept;
  logic a_listed, ok;
  idx_t next_rd, prev_rd, nxt, prv;
  err_t a_err;

  assign in_idx  = to_idx(task_req);
  assign advance = a_valid && (!out_valid || out_ready);
  assign in_ready = !a_valid || advance;
  assign accept  = in_valid && in_ready;

  rlq_ram #(.WIDTH(IDX_W), .DEPTH(NUM_TASKS)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (accept),
    .raddr (in_idx),
    .rdata (next_rdata)
  );

  rlq_ram #(.WIDTH(IDX_W), .DEPTH(NUM_TASKS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (accept),
    .raddr (in_idx),
    .rdata (prev_rdata)
  );

  // Capture the request; forward a link written in the same cycle as the read
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      next_byp <= 1'b0;
      prev_byp <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (accept) begin
        next_byp <= next_we && (next_waddr == in_idx);
        prev_byp <= prev_we && (prev_waddr == in_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_req.func     <= func_t'(func);
      a_req.idx      <= in_idx;
      a_req.in_range <= task_in_range(task_req);
      next_byp_data  <= next_wdata;
      prev_byp_data  <= prev_wdata;
    end
  end

  // Resolve neighbors of the requested task
  assign next_rd  = next_byp ? next_byp_data : next_rdata;
  assign prev_rd  = prev_byp ? prev_byp_data : prev_rdata;
  assign nxt      = (a_req.idx == tail) ? head : next_rd;
  assign prv      = (a_req.idx == head) ? tail : prev_rd;
  assign a_listed = a_req.in_range && listed[a_req.idx];

  // Check the request
  always_comb begin
    unique case (a_req.func)
      FUNC_ADD: begin
        ok    = a_req.in_range && !a_listed;
        a_err = ok ? ERR_OK : ERR_ADD_LISTED;
      end
      FUNC_REMOVE: begin
        ok    = a_listed && !empty_flag;
        a_err = ok ? ERR_OK : ERR_REMOVE_UNLISTED;
      end
      default: begin
        ok    = 1'b0;
        a_err = ERR_OK;
      end
    endcase
  end

  // Link update for an accepted add or remove
  always_comb begin
    listed_next = listed;
    head_next   = head;
    tail_next   = tail;
    empty_next  = empty_flag;
    next_we     = 1'b0;
    prev_we     = 1'b0;
    next_waddr  = tail;
    next_wdata  = a_req.idx;
    prev_waddr  = a_req.idx;
    prev_wdata  = tail;
    if (advance && ok) begin
      unique case (a_req.func)
        FUNC_ADD: begin
          listed_next[a_req.idx] = 1'b1;
          tail_next              = a_req.idx;
          if (empty_flag) begin
            head_next  = a_req.idx;
            empty_next = 1'b0;
          end else begin
            next_we = 1'b1;
            prev_we = 1'b1;
          end
        end
        FUNC_REMOVE: begin
          listed_next[a_req.idx] = 1'b0;
          if (nxt == a_req.idx) begin
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
          end else begin
            prev_we    = 1'b1;
            prev_waddr = nxt;
            prev_wdata = prv;
            next_we    = 1'b1;
            next_waddr = prv;
            next_wdata = nxt;
            if (a_req.idx == head) begin
              head_next = nxt;
            end
            if (a_req.idx == tail) begin
              tail_next = prv;
            end
          end
        end
        default: begin
          next_we = 1'b0;
        end
      endcase
    end
  end

  // Hold list state
  always_ff @(posedge clk) begin
    if (rst) begin
      listed     <= '0;
      head       <= '0;
      tail       <= '0;
      empty_flag <= 1'b1;
    end else begin
      listed     <= listed_next;
      head       <= head_next;
      tail       <= tail_next;
      empty_flag <= empty_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      list_empty <= empty_next;
      first_task <= empty_next ? '0 : TASK_W'(head_next);
      error      <= a_err;
    end
  end

  // Empty list has its head at zero and no members
  a_empty_head : assert property (@(posedge clk) disable iff (rst)
    empty_flag |-> (head == '0) && (listed == '0))
    else $error("empty list with head or members set");

  // Non-empty list has listed head and tail
  a_ends_listed : assert property (@(posedge clk) disable iff (rst)
    !empty_flag |-> listed[head] && listed[tail])
    else $error("head or tail not listed");

  // Refused request leaves the list untouched
  a_refused_stable : assert property (@(posedge clk) disable iff (rst)
    (advance && !ok) |=> $stable(listed) && $stable(head) && $stable(tail))
    else $error("refused request changed the list");

  // Single member: head and tail coincide
  a_single_member : assert property (@(posedge clk) disable iff (rst)
    (!empty_flag && $countones(listed) == 1) |-> (head == tail))
    else $error("single member with head and tail apart");

endmodule

>>> rtl/core/rlq_ram.sv
module rlq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> tb/sv/ready_list_linked_queue_top_tb.sv
`timescale 1ns / 1ps

module ready_list_linked_queue_top_tb;
  import rlq_pkg::*;

  localparam int N_DIRECTED      = 23;
  localparam int N_RANDOM        = 1030;
  localparam int IDLE_PCT        = 7;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_PRINTS      = 40;
  localparam int CALM_FIRST      = 200;
  localparam int CALM_LAST       = 420;
  localparam int PAUSE_AT        = 550;
  localparam int HOLD_AT         = 700;

  // One result transaction
  typedef struct packed {
    logic  empty;
    task_t first;
    err_t  err;
  } list_status_t;

  // One row of the directed table; status is used only when typed is set
  typedef struct packed {
    func_t        op;
    task_t        tnum;
    logic         typed;
    list_status_t status;
  } stim_row_t;

  localparam stim_row_t DIRECTED[N_DIRECTED] = '{
    '{FUNC_REMOVE, 6'd5,  1'b1, '{1'b1, 6'd0,  ERR_REMOVE_UNLISTED}},
    '{FUNC_ADD,    6'd0,  1'b1, '{1'b0, 6'd0,  ERR_OK}},
    '{FUNC_ADD,    6'd0,  1'b1, '{1'b0, 6'd0,  ERR_ADD_LISTED}},
    '{FUNC_ADD,    6'd63, 1'b1, '{1'b0, 6'd0,  ERR_OK}},
    '{FUNC_ADD,    6'd42, 1'b1, '{1'b0, 6'd0,  ERR_OK}},
    '{FUNC_ADD,    6'd21, 1'b1, '{1'b0, 6'd0,  ERR_OK}},
    '{FUNC_REMOVE, 6'd42, 1'b0, '{1'b0, 6'd0,  ERR_OK}},
    '{FUNC_REMOVE, 6'd0,  1'b0, '{1'b0, 6'd0,  ERR_OK}},
    '{FUNC_REMOVE, 6'd0,  1'b0, '{1'b0, 6'd0,  ERR_OK}},
    '{FUNC_ADD,    6'd42, 1'b0, '{1'b0, 6'd0,  ERR_OK}},
    '{FUNC_REMOVE, 6'd21, 1'b0, '{1'b0, 6'd0,  ERR_OK}},
    '{FUNC_REMOVE, 6'd42, 1'b0, '{1'b0, 6'd0,  ERR_OK}},
    '{FUNC_REMOVE, 6'd63, 1'b1, '{1'b1, 6'd0,  ERR_OK}},
    '{FUNC_REMOVE, 6'd63, 1'b1, '{1'b1, 6'd0,  ERR_REMOVE_UNLISTED}},
    '{FUNC_ADD,    6'd63, 1'b1, '{1'b0, 6'd63, ERR_OK}},
    '{FUNC_ADD,    6'd63, 1'b1, '{1'b0, 6'd63, ERR_ADD_LISTED}},
    '{FUNC_ADD,    6'd1,  1'b0, '{1'b0, 6'd0,  ERR_OK}},
    '{FUNC_ADD,    6'd2,  1'b0, '{1'b0, 6'd0,  ERR_OK}},
    '{FUNC_REMOVE, 6'd63, 1'b0, '{1'b0, 6'd0,  ERR_OK}},
    '{FUNC_REMOVE, 6'd1,  1'b0, '{1'b0, 6'd0,  ERR_OK}},
    '{FUNC_REMOVE, 6'd2,  1'b1, '{1'b1, 6'd0,  ERR_OK}},
    '{FUNC_ADD,    6'd0,  1'b0, '{1'b0, 6'd0,  ERR_OK}},
    '{FUNC_REMOVE, 6'd0,  1'b1, '{1'b1, 6'd0,  ERR_OK}}
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       func;
  logic [5:0] task_req;
  logic       out_valid;
  logic       out_ready;
  logic       list_empty;
  logic [5:0] first_task;
  logic [1:0] error;

  // Shadow copy of the ready list
  idx_t link_next [NUM_TASKS];
  idx_t link_prev [NUM_TASKS];
  logic on_list   [NUM_TASKS];
  idx_t head_idx;
  logic list_is_empty;
  int   list_len;

  list_status_t pending_status[$];

  int  mismatches;
  int  n_adds, n_removes, n_refused, n_emptied, peak_len, n_results;
  bit  calm;
  int  holds_asked, holds_done;
  int  quiet_cycles;

  ready_list_linked_queue_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .task_req   (task_req),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .list_empty (list_empty),
    .first_task (first_task),
    .error      (error)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Apply one request to the shadow list and return the status it reports
  function automatic list_status_t list_apply(input func_t op, input task_t tnum);
    list_status_t st;
    idx_t         i;
    idx_t         tl;
    idx_t         nx;
    idx_t         pv;
    i      = idx_t'(tnum);
    st.err = ERR_OK;
    if (op == FUNC_ADD) begin
      if (int'(tnum) >= NUM_TASKS || on_list[i]) begin
        st.err = ERR_ADD_LISTED;
      end else begin
        if (list_is_empty) begin
          link_next[i]  = i;
          link_prev[i]  = i;
          head_idx      = i;
          list_is_empty = 1'b0;
        end else begin
          tl                  = link_prev[head_idx];
          link_next[i]        = head_idx;
          link_prev[i]        = tl;
          link_prev[head_idx] = i;
          link_next[tl]       = i;
        end
        on_list[i] = 1'b1;
        list_len++;
      end
    end else begin
      if (int'(tnum) >= NUM_TASKS || !on_list[i] || list_is_empty) begin
        st.err = ERR_REMOVE_UNLISTED;
      end else begin
        nx         = link_next[i];
        pv         = link_prev[i];
        on_list[i] = 1'b0;
        list_len--;
        if (nx == i) begin
          head_idx      = '0;
          list_is_empty = 1'b1;
        end else begin
          link_prev[nx] = pv;
          link_next[pv] = nx;
          if (head_idx == i) head_idx = nx;
        end
      end
    end
    st.empty = list_is_empty;
    st.first = list_is_empty ? '0 : task_t'(head_idx);
    return st;
  endfunction

  // Pick a request: mostly legal adds and removes steered toward a fill goal
  function automatic void pick_request(input int fill_goal, output func_t op,
                                       output task_t tnum);
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      op   = func_t'($urandom_range(1));
      tnum = task_t'($urandom_range(63));
    end else if (r < 13 && list_len > 0 && list_len < NUM_TASKS) begin
      // refused request: add a listed task or remove an unlisted one
      op = func_t'($urandom_range(1));
      do tnum = task_t'($urandom_range(63));
      while (on_list[idx_t'(tnum)] != (op == FUNC_ADD));
    end else begin
      if (list_len == 0) op = FUNC_ADD;
      else if (list_len == NUM_TASKS) op = FUNC_REMOVE;
      else if (list_len < fill_goal) op = ($urandom_range(99) < 85) ? FUNC_ADD : FUNC_REMOVE;
      else op = ($urandom_range(99) < 75) ? FUNC_REMOVE : FUNC_ADD;
      if (op == FUNC_ADD) begin
        do tnum = task_t'($urandom_range(63));
        while (on_list[idx_t'(tnum)]);
      end else begin
        r = $urandom_range(99);
        // favor the head and the tail, where the links wrap
        if (r < 25) tnum = task_t'(head_idx);
        else if (r < 35) tnum = task_t'(link_prev[head_idx]);
        else begin
          do tnum = task_t'($urandom_range(63));
          while (!on_list[idx_t'(tnum)]);
        end
      end
    end
  endfunction

  // Offer one request, hold it until taken, then record what it should return
  task automatic send_request(input func_t op, input task_t tnum, input logic typed,
                              input list_status_t typed_status);
    list_status_t st;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    func     <= op;
    task_req <= tnum;
    do @(posedge clk); while (!in_ready);
    st = list_apply(op, tnum);
    pending_status.push_back(typed ? typed_status : st);
    if (st.err != ERR_OK) n_refused++;
    else if (op == FUNC_ADD) n_adds++;
    else n_removes++;
    if (st.err == ERR_OK && op == FUNC_REMOVE && st.empty) n_emptied++;
    if (list_len > peak_len) peak_len = list_len;
  endtask

  // Drop valid and hold until every pending result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, or a long hold-off when one is asked for
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_asked != holds_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each result transaction with the oldest pending status
  always @(posedge clk) begin
    list_status_t exp_st;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_status.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: empty=%0b first=%0d err=%0d",
                                  list_empty, first_task, error));
      end else begin
        exp_st = pending_status.pop_front();
        if (list_empty !== exp_st.empty)
          report_mismatch($sformatf("list_empty %0b, expected %0b", list_empty, exp_st.empty));
        if (first_task !== exp_st.first)
          report_mismatch($sformatf("first_task %0d, expected %0d", first_task, exp_st.first));
        if (error !== exp_st.err)
          report_mismatch($sformatf("error %0d, expected %0d", error, exp_st.err));
      end
    end
  end

  // Abort when no transaction moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d idle cycles, %0d results pending",
               quiet_cycles, pending_status.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    func_t op;
    task_t tnum;
    int    fill_goal;
    rst           = 1'b1;
    in_valid      = 1'b0;
    func          = FUNC_ADD;
    task_req      = '0;
    calm          = 1'b0;
    holds_asked   = 0;
    holds_done    = 0;
    quiet_cycles  = 0;
    mismatches    = 0;
    n_adds        = 0;
    n_removes     = 0;
    n_refused     = 0;
    n_emptied     = 0;
    peak_len      = 0;
    n_results     = 0;
    list_len      = 0;
    head_idx      = '0;
    list_is_empty = 1'b1;
    fill_goal     = 8;
    for (int k = 0; k < NUM_TASKS; k++) on_list[k] = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (DIRECTED[k])
      send_request(DIRECTED[k].op, DIRECTED[k].tnum, DIRECTED[k].typed, DIRECTED[k].status);

    // Random traffic with a moving fill goal
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 80 == 0)
        fill_goal = ($urandom_range(3) == 0) ? NUM_TASKS : $urandom_range(1, NUM_TASKS - 1);
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      if (n == PAUSE_AT) drain_results();
      if (n == HOLD_AT) holds_asked++;
      pick_request(fill_goal, op, tnum);
      send_request(op, tnum, 1'b0, '0);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d adds, %0d removes, %0d refused; %0d results checked",
             N_DIRECTED + N_RANDOM, n_adds, n_removes, n_refused, n_results);
    $display("List peaked at %0d of %0d tasks and was emptied %0d times by a remove",
             peak_len, NUM_TASKS, n_emptied);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/rlq_pkg.sv
rtl/core/rlq_ram.sv
rtl/core/ready_list_linked_queue_top.sv
tb/sv/ready_list_linked_queue_top_tb.sv
